FILE: sv/psrm_pkg.sv
// ----------------------------------------------------------------------------
// psrm_pkg - shared types and constants for the positional range-min core
// Holds the default capacity, the empty-range marker, the item kind codes
// and the link word handed from one sequence cell to the next.
// ----------------------------------------------------------------------------
package psrm_pkg;

   localparam int CAPACITY_DEFAULT = 1024;
   localparam int FIELD_POS_W      = 11;
   localparam int VALUE_W          = 32;

   localparam logic signed [VALUE_W-1:0] EMPTY_MIN = 32'sd2000000000;

   typedef enum logic {
      KIND_INSERT = 1'b0,
      KIND_QUERY  = 1'b1
   } kind_type;

   // running minimum that walks down the row of cells
   typedef struct packed {
      logic                      wave;
      logic                      found;
      logic signed [VALUE_W-1:0] min;
   } link_type;

endpackage

FILE: sv/psrm_cell.sv
// ----------------------------------------------------------------------------
// psrm_cell - one position of the ordered sequence
// Holds one value, loads the new value or its lower neighbor's on insert
// and folds it into the passing running minimum when its position is in range.
// ----------------------------------------------------------------------------
module psrm_cell #(
   parameter int INDEX = 0,
   parameter int IW    = 11
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 shift,
   input  logic [IW-1:0]                        pos,
   input  logic signed [psrm_pkg::VALUE_W-1:0]  value_new,
   input  logic [IW-1:0]                        lo,
   input  logic [IW-1:0]                        hi,
   input  logic signed [psrm_pkg::VALUE_W-1:0]  prev_value,
   input  psrm_pkg::link_type                   link_in,
   output logic signed [psrm_pkg::VALUE_W-1:0]  own_value,
   output psrm_pkg::link_type                   link_out
);

   localparam logic [IW-1:0] IDX = IW'(INDEX);

   logic signed [psrm_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                                wave_ff;
   logic                                found_ff, found_in;
   logic signed [psrm_pkg::VALUE_W-1:0] min_ff, min_in;
   logic                                hit;

   assign hit = (IDX >= lo) && (IDX < hi);

   always_comb begin
      value_in = value_ff;
      if (shift) begin
         if (IDX > pos) begin
            value_in = prev_value;
         end else if (IDX == pos) begin
            value_in = value_new;
         end
      end
   end

   always_comb begin
      found_in = link_in.found;
      min_in   = link_in.min;
      if (hit && (!link_in.found || (value_ff < link_in.min))) begin
         found_in = 1'b1;
         min_in   = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (link_in.wave) begin
         found_ff <= found_in;
         min_ff   <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= 1'b0;
      end else begin
         wave_ff <= link_in.wave;
      end
   end

   assign own_value      = value_ff;
   assign link_out.wave  = wave_ff;
   assign link_out.found = found_ff;
   assign link_out.min   = min_ff;

endmodule

FILE: sv/positional_sequence_range_min_core.sv
// Insert: in ST_INS the cells at and above the position shift (none when full)
// and the result is registered. Query: the minimum moves one cell per cycle and
// the result is registered once the wave leaves the last cell. One item at a time:
// the next word is taken once the previous one is done and its result has left or
// is leaving. Synchronous active-high reset clears the count, control and handshakes;
// stored values are not cleared and only written positions are ever read.
// ----------------------------------------------------------------------------
// positional_sequence_range_min_core - ordered sequence with range minimum
// A row of cells holds the sequence; inserts shift the tail up by one place,
// queries send a running minimum down the row over the clamped range.
// ----------------------------------------------------------------------------
module positional_sequence_range_min_core #(
   parameter int CAPACITY = psrm_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [10:0] position, [42:11] value, [53:43] range_start,
   // [64:54] range_end, [71:65] zero
   input  logic [71:0] req_tdata,
   // [0] kind
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [31:0] min_value
   output logic [31:0] rsp_tdata,
   // [0] range_empty, [1] insert_dropped
   output logic [1:0]  rsp_tuser
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CW > psrm_pkg::FIELD_POS_W) ? CW : psrm_pkg::FIELD_POS_W;
   localparam int VW = psrm_pkg::VALUE_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_INS  = 3'b010,
      ST_QRY  = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    launch_ff, launch_in;
   logic [IW-1:0]           pos_ff, lo_ff, hi_ff;
   logic signed [VW-1:0]    newval_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [VW-1:0]    rsp_min_ff, rsp_min_in;
   logic                    rsp_empty_ff, rsp_empty_in;
   logic                    rsp_drop_ff, rsp_drop_in;

   logic                    req_take;
   logic                    full;
   logic                    shift;
   logic [IW-1:0]           count_x, req_pos_x, req_start_x, req_end_x;
   logic [IW-1:0]           pos_eff, lo_eff, hi_eff;

   logic signed [VW-1:0]    vals [CAPACITY];
   psrm_pkg::link_type      chain [CAPACITY+1];

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_take   = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(CAPACITY));
   assign shift      = (state_ff == ST_INS) && !full;

   assign count_x     = IW'(count_ff);
   assign req_pos_x   = IW'(req_tdata[10:0]);
   assign req_start_x = IW'(req_tdata[53:43]);
   assign req_end_x   = IW'(req_tdata[64:54]);

   assign pos_eff = (req_pos_x > count_x) ? count_x : req_pos_x;
   assign lo_eff  = (req_start_x > count_x) ? count_x : req_start_x;
   assign hi_eff  = (req_end_x < req_start_x) ? count_x :
                    ((req_end_x > count_x) ? count_x : req_end_x);

   // register the word; the cells act on it in the next cycle
   always_ff @(posedge clock) begin
      if (req_take) begin
         pos_ff    <= pos_eff;
         newval_ff <= req_tdata[42:11];
         lo_ff     <= lo_eff;
         hi_ff     <= hi_eff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      launch_in    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_min_in   = rsp_min_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_drop_in  = rsp_drop_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_tuser[0] == psrm_pkg::KIND_QUERY) begin
                  state_in  = ST_QRY;
                  launch_in = 1'b1;
               end else begin
                  state_in = ST_INS;
               end
            end
         end
         ST_INS: begin
            if (!full) begin
               count_in = count_ff + CW'(1);
            end
            rsp_valid_in = 1'b1;
            rsp_min_in   = '0;
            rsp_empty_in = 1'b0;
            rsp_drop_in  = full;
            state_in     = ST_IDLE;
         end
         ST_QRY: begin
            // take the minimum once the wave leaves the last cell
            if (chain[CAPACITY].wave) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = chain[CAPACITY].found ? chain[CAPACITY].min
                                                    : psrm_pkg::EMPTY_MIN;
               rsp_empty_in = !chain[CAPACITY].found;
               rsp_drop_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_min_ff   <= rsp_min_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign chain[0].wave  = launch_ff;
   assign chain[0].found = 1'b0;
   assign chain[0].min   = psrm_pkg::EMPTY_MIN;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VW-1:0] prev_value;
      if (i == 0) begin : g_first
         assign prev_value = '0;
      end else begin : g_rest
         assign prev_value = vals[i-1];
      end
      psrm_cell #(
         .INDEX (i),
         .IW    (IW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift      (shift),
         .pos        (pos_ff),
         .value_new  (newval_ff),
         .lo         (lo_ff),
         .hi         (hi_ff),
         .prev_value (prev_value),
         .link_in    (chain[i]),
         .own_value  (vals[i]),
         .link_out   (chain[i+1])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_min_ff;
   assign rsp_tuser  = {rsp_drop_ff, rsp_empty_ff};

endmodule

FILE: sv/psrm_checker.sv
// ----------------------------------------------------------------------------
// psrm_checker - port-level checks for the positional range-min core
// Watches the request and response channels and flags results that break
// the block's rules on flags, the empty marker and one item in flight.
// ----------------------------------------------------------------------------
module psrm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [71:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   logic req_take;
   assign req_take = req_tvalid && req_tready && (req_tdata[71:65] == 7'd0 ||
                     req_tdata[71:65] != 7'd0) && (req_tuser[0] || !req_tuser[0]);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // an empty range always carries the empty marker
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'd2000000000)
      else $error("empty range without marker value");

   // a dropped insert reports neither empty flag nor a value
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && rsp_tdata == 32'd0)
      else $error("dropped insert with query fields set");

   // one word in flight: after a take the block is busy and the output is free
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_tready && !rsp_tvalid)
      else $error("new word or stale result right after a take");

endmodule

bind positional_sequence_range_min_core psrm_checker u_psrm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
